@@ sv/steer_and_speed_pid_core_macros.svh @@
// ----------------------------------------------------------------------------
// steer_and_speed_pid_core_macros
// Assertion helpers shared by the steering and speed controller RTL.
// ----------------------------------------------------------------------------
`ifndef STEER_AND_SPEED_PID_CORE_MACROS_SVH
`define STEER_AND_SPEED_PID_CORE_MACROS_SVH

// consequent checked in the same cycle
`define SSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg
// Types, widths and constants of the steering and speed controller.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int GAIN_W   = 18;
  localparam int TGT_W    = 13;
  localparam int LINE_W   = 8;
  localparam int CNT_W    = 16;
  localparam int SERVO_W  = 11;
  localparam int POWER_W  = 10;
  localparam int STEER_W  = 9;
  localparam int DSTEER_W = 10;
  localparam int SQ_W     = 17;
  localparam int SPD_W    = 16;
  localparam int DSPD_W   = 17;
  localparam int DRV_W    = 32;
  localparam int REM_W    = 17;
  localparam int MAG_W    = 15;
  localparam int QUO_W    = 8;
  localparam int DIFF_W   = 17;

  localparam int MA_W     = 18;
  localparam int MB_W     = 18;
  localparam int PROD_W   = MA_W + 1 + MB_W;
  localparam int SUM_W    = 44;
  localparam int Q_BITS   = 10;
  localparam int QSUM_W   = SUM_W - Q_BITS;
  localparam int Q_MASK   = (1 << Q_BITS) - 1;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  // crossing remap: (135*x - 1365) / 100, division as reciprocal multiply
  localparam int REMAP_MUL   = 135;
  localparam int REMAP_OFS   = 1365;
  localparam int RECIP_MUL   = 20972;
  localparam int RECIP_SH    = 21;
  localparam int LINE_OFS    = 39;
  localparam int COUNT_LIMIT = 5000;

  typedef enum logic [IDX_W-1:0] {
    REG_LEFT_KP  = 3'd0,
    REG_LEFT_KD  = 3'd1,
    REG_RIGHT_KP = 3'd2,
    REG_RIGHT_KD = 3'd3,
    REG_SPEED_KP = 3'd4,
    REG_SPEED_KI = 3'd5,
    REG_SLOWDOWN = 3'd6,
    REG_TARGET   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] left_prop_gain;
    logic [GAIN_W-1:0] left_diff_gain;
    logic [GAIN_W-1:0] right_prop_gain;
    logic [GAIN_W-1:0] right_diff_gain;
    logic [GAIN_W-1:0] speed_prop_gain;
    logic [GAIN_W-1:0] speed_int_gain;
    logic [GAIN_W-1:0] curve_slowdown_gain;
    logic [TGT_W-1:0]  target_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    left_prop_gain:      GAIN_W'(1331),
    left_diff_gain:      GAIN_W'(76800),
    right_prop_gain:     GAIN_W'(1331),
    right_diff_gain:     GAIN_W'(76800),
    speed_prop_gain:     GAIN_W'(922),
    speed_int_gain:      GAIN_W'(10),
    curve_slowdown_gain: GAIN_W'(1024),
    target_speed:        TGT_W'(0)
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_RMUL, ST_RABS, ST_RDIV, ST_RFIX, ST_ERR, ST_SQ, ST_KP, ST_KD,
    ST_SSUM, ST_SLOW, ST_NUM, ST_SERR, ST_PMUL, ST_IMUL, ST_ASUM, ST_DRV, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_REMAP, MUL_RECIP, MUL_SQ, MUL_KP, MUL_KD, MUL_SLOW, MUL_SP,
    MUL_SI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_SERVO, ACC_DIFF, ACC_DRIVE, ACC_ADD, ACC_SLOW
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     mul_en;
    acc_op_t  acc_op;
    logic     ld_in;
    logic     ld_mag;
    logic     ld_remap;
    logic     ld_err;
    logic     ld_sq;
    logic     ld_servo;
    logic     ld_serr;
    logic     ld_drive;
    logic     ld_out;
  } ctrl_t;

endpackage

@@ sv/steer_and_speed_pid_core.sv @@
// ----------------------------------------------------------------------------
// steer_and_speed_pid_core
// Steering PD and incremental speed PI, one control tick per request.
//
//   channel  handshake           payload
//   in       in_valid/in_ready   in_centre_line, in_at_crossing, in_wheel_count
//   out      out_valid/out_ready out_servo_angle, out_motor_power,
//                                out_motor_clockwise
//   cfg      psel/penable/pready paddr, pwdata, prdata (8 regs at 4*i)
//
// A crossing remap adds the RMUL, RABS, RDIV and RFIX steps before the error step;
// the next request is taken in the cycle after the result loads.
// The steps share the single multiplier, at most one product per step.
// Reset is synchronous; gains return to defaults and controller history clears.
// A held result stalls only the final step; the output register frees the core.
// ----------------------------------------------------------------------------
`include "steer_and_speed_pid_core_macros.svh"

module steer_and_speed_pid_core #(
  parameter int SERVO_CENTER = 935,
  parameter int SERVO_MIN    = 600,
  parameter int SERVO_MAX    = 1270,
  parameter int MOTOR_MAX    = 600
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ssp_pkg::LINE_W-1:0]  in_centre_line,
  input  logic                               in_at_crossing,
  input  logic signed [ssp_pkg::CNT_W-1:0]   in_wheel_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ssp_pkg::SERVO_W-1:0]        out_servo_angle,
  output logic [ssp_pkg::POWER_W-1:0]        out_motor_power,
  output logic                               out_motor_clockwise,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ssp_pkg::ADDR_W-1:0]         paddr,
  input  logic [ssp_pkg::DATA_W-1:0]         pwdata,
  output logic [ssp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import ssp_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  servo_ok;
  logic  power_zero;

  ssp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssp_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_at_crossing (in_at_crossing),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ctrl           (ctrl)
  );

  ssp_dp #(
    .SERVO_CENTER (SERVO_CENTER),
    .SERVO_MIN    (SERVO_MIN),
    .SERVO_MAX    (SERVO_MAX),
    .MOTOR_MAX    (MOTOR_MAX)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .cfg                 (cfg),
    .in_centre_line      (in_centre_line),
    .in_wheel_count      (in_wheel_count),
    .out_servo_angle     (out_servo_angle),
    .out_motor_power     (out_motor_power),
    .out_motor_clockwise (out_motor_clockwise)
  );

  assign servo_ok   = (out_servo_angle >= SERVO_W'(SERVO_MIN)) &&
                      (out_servo_angle <= SERVO_W'(SERVO_MAX));
  assign power_zero = out_valid && (out_motor_power == '0);

  `SSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `SSP_ASSERT_SAME(a_servo_range, out_valid, servo_ok, "servo out of range")
  `SSP_ASSERT_SAME(a_power_limit, out_valid, out_motor_power <= POWER_W'(MOTOR_MAX), "power over limit")
  `SSP_ASSERT_SAME(a_zero_dir, power_zero, out_motor_clockwise, "zero drive direction")

endmodule

@@ sv/ssp_cfg.sv @@
// ----------------------------------------------------------------------------
// ssp_cfg
// APB register bank holding the controller gains and the target speed.
// ----------------------------------------------------------------------------
module ssp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssp_pkg::ADDR_W-1:0]    paddr,
  input  logic [ssp_pkg::DATA_W-1:0]    pwdata,
  output logic [ssp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output ssp_pkg::cfg_t                 cfg
);
  import ssp_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_LEFT_KP:  cfg_r.left_prop_gain      <= pwdata[GAIN_W-1:0];
        REG_LEFT_KD:  cfg_r.left_diff_gain      <= pwdata[GAIN_W-1:0];
        REG_RIGHT_KP: cfg_r.right_prop_gain     <= pwdata[GAIN_W-1:0];
        REG_RIGHT_KD: cfg_r.right_diff_gain     <= pwdata[GAIN_W-1:0];
        REG_SPEED_KP: cfg_r.speed_prop_gain     <= pwdata[GAIN_W-1:0];
        REG_SPEED_KI: cfg_r.speed_int_gain      <= pwdata[GAIN_W-1:0];
        REG_SLOWDOWN: cfg_r.curve_slowdown_gain <= pwdata[GAIN_W-1:0];
        REG_TARGET:   cfg_r.target_speed        <= pwdata[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEFT_KP:  prdata = DATA_W'(cfg_r.left_prop_gain);
      REG_LEFT_KD:  prdata = DATA_W'(cfg_r.left_diff_gain);
      REG_RIGHT_KP: prdata = DATA_W'(cfg_r.right_prop_gain);
      REG_RIGHT_KD: prdata = DATA_W'(cfg_r.right_diff_gain);
      REG_SPEED_KP: prdata = DATA_W'(cfg_r.speed_prop_gain);
      REG_SPEED_KI: prdata = DATA_W'(cfg_r.speed_int_gain);
      REG_SLOWDOWN: prdata = DATA_W'(cfg_r.curve_slowdown_gain);
      REG_TARGET:   prdata = DATA_W'(cfg_r.target_speed);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ sv/ssp_mul.sv @@
// ----------------------------------------------------------------------------
// ssp_mul
// Shared multiplier: unsigned gain times signed operand, registered product.
// ----------------------------------------------------------------------------
module ssp_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic [ssp_pkg::MA_W-1:0]           a,
  input  logic signed [ssp_pkg::MB_W-1:0]    b,
  output logic signed [ssp_pkg::PROD_W-1:0]  prod_r
);
  import ssp_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = $signed({1'b0, a}) * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ sv/ssp_seq.sv @@
// ----------------------------------------------------------------------------
// ssp_seq
// Step sequencer: walks one request through the shared multiplier schedule.
// ----------------------------------------------------------------------------
module ssp_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_at_crossing,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ssp_pkg::ctrl_t ctrl
);
  import ssp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_at_crossing ? ST_RMUL : ST_ERR;
        end
      end
      ST_RMUL: state_nxt = ST_RABS;
      ST_RABS: state_nxt = ST_RDIV;
      ST_RDIV: state_nxt = ST_RFIX;
      ST_RFIX: state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_KP;
      ST_KP:   state_nxt = ST_KD;
      ST_KD:   state_nxt = ST_SSUM;
      ST_SSUM: state_nxt = ST_SLOW;
      ST_SLOW: state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_SERR;
      ST_SERR: state_nxt = ST_PMUL;
      ST_PMUL: state_nxt = ST_IMUL;
      ST_IMUL: state_nxt = ST_ASUM;
      ST_ASUM: state_nxt = ST_DRV;
      ST_DRV:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.mul_sel = MUL_NONE;
    ctrl.acc_op  = ACC_HOLD;
    case (state_r)
      ST_IDLE: ctrl.ld_in = in_valid;
      ST_RMUL: begin
        ctrl.mul_sel = MUL_REMAP;
        ctrl.mul_en  = 1'b1;
      end
      ST_RABS: ctrl.ld_mag = 1'b1;
      ST_RDIV: begin
        ctrl.mul_sel = MUL_RECIP;
        ctrl.mul_en  = 1'b1;
      end
      ST_RFIX: ctrl.ld_remap = 1'b1;
      ST_ERR:  ctrl.ld_err = 1'b1;
      ST_SQ: begin
        ctrl.mul_sel = MUL_SQ;
        ctrl.mul_en  = 1'b1;
      end
      ST_KP: begin
        ctrl.ld_sq   = 1'b1;
        ctrl.mul_sel = MUL_KP;
        ctrl.mul_en  = 1'b1;
        ctrl.acc_op  = ACC_SERVO;
      end
      ST_KD: begin
        ctrl.mul_sel = MUL_KD;
        ctrl.mul_en  = 1'b1;
        ctrl.acc_op  = ACC_ADD;
      end
      ST_SSUM: ctrl.acc_op = ACC_ADD;
      ST_SLOW: begin
        ctrl.ld_servo = 1'b1;
        ctrl.mul_sel  = MUL_SLOW;
        ctrl.mul_en   = 1'b1;
        ctrl.acc_op   = ACC_DIFF;
      end
      ST_NUM:  ctrl.acc_op = ACC_SLOW;
      ST_SERR: ctrl.ld_serr = 1'b1;
      ST_PMUL: begin
        ctrl.mul_sel = MUL_SP;
        ctrl.mul_en  = 1'b1;
        ctrl.acc_op  = ACC_DRIVE;
      end
      ST_IMUL: begin
        ctrl.mul_sel = MUL_SI;
        ctrl.mul_en  = 1'b1;
        ctrl.acc_op  = ACC_ADD;
      end
      ST_ASUM: ctrl.acc_op = ACC_ADD;
      ST_DRV:  ctrl.ld_drive = 1'b1;
      ST_OUT:  ctrl.ld_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/ssp_dp.sv @@
// ----------------------------------------------------------------------------
// ssp_dp
// Datapath: operand select, shared multiplier, accumulator, clamps, state.
// ----------------------------------------------------------------------------
module ssp_dp #(
  parameter int SERVO_CENTER = 935,
  parameter int SERVO_MIN    = 600,
  parameter int SERVO_MAX    = 1270,
  parameter int MOTOR_MAX    = 600
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssp_pkg::ctrl_t                      ctrl,
  input  ssp_pkg::cfg_t                       cfg,
  input  logic signed [ssp_pkg::LINE_W-1:0]   in_centre_line,
  input  logic signed [ssp_pkg::CNT_W-1:0]    in_wheel_count,
  output logic [ssp_pkg::SERVO_W-1:0]         out_servo_angle,
  output logic [ssp_pkg::POWER_W-1:0]         out_motor_power,
  output logic                                out_motor_clockwise
);
  import ssp_pkg::*;

  logic signed [STEER_W-1:0]  line_r, e_r, last_steer_r;
  logic signed [CNT_W-1:0]    wheel_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r;
  logic signed [SQ_W-1:0]     sq_r;
  logic signed [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SERVO_W-1:0]         servo_r, servo_nxt;
  logic signed [SPD_W-1:0]    spd_err_r, spd_err_nxt, last_speed_r;
  logic signed [DRV_W-1:0]    drive_r, drive_nxt;
  logic [SERVO_W-1:0]         servo_out_r;
  logic [POWER_W-1:0]         power_r, power_nxt;
  logic                       cw_r;

  logic [MA_W-1:0]            mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]    prod_ext;

  logic [STEER_W-1:0]         e_abs;
  logic signed [DSTEER_W-1:0] d_steer;
  logic [SQ_W-1:0]            sq_abs;
  logic signed [DSPD_W-1:0]   d_spd;
  logic [GAIN_W-1:0]          kp_sel, kd_sel;
  logic signed [REM_W-1:0]    rem_t;
  logic [MAG_W-1:0]           mag_nxt;
  logic [QUO_W-1:0]           quo;
  logic signed [STEER_W-1:0]  quo_s, line_remap, e_nxt;
  logic                       count_big;
  logic signed [DIFF_W-1:0]   spd_diff;
  logic signed [SUM_W-1:0]    acc_rnd;
  logic signed [QSUM_W-1:0]   acc_fl, acc_q;
  logic signed [DRV_W:0]      drv_ext;
  logic [DRV_W:0]             drv_mag;

  assign e_abs   = e_r[STEER_W-1] ? STEER_W'(-e_r) : STEER_W'(e_r);
  assign d_steer = DSTEER_W'(e_r) - DSTEER_W'(last_steer_r);
  assign sq_abs  = sq_r[SQ_W-1] ? SQ_W'(-sq_r) : SQ_W'(sq_r);
  assign d_spd   = DSPD_W'(spd_err_r) - DSPD_W'(last_speed_r);
  assign kp_sel  = e_r[STEER_W-1] ? cfg.left_prop_gain : cfg.right_prop_gain;
  assign kd_sel  = e_r[STEER_W-1] ? cfg.left_diff_gain : cfg.right_diff_gain;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_REMAP: begin
        mul_a = MA_W'(REMAP_MUL);
        mul_b = MB_W'(line_r);
      end
      MUL_RECIP: begin
        mul_a = MA_W'(RECIP_MUL);
        mul_b = $signed(MB_W'(mag_r));
      end
      MUL_SQ: begin
        mul_a = MA_W'(e_abs);
        mul_b = MB_W'(e_r);
      end
      MUL_KP: begin
        mul_a = kp_sel;
        mul_b = MB_W'($signed(prod_r[SQ_W-1:0]));
      end
      MUL_KD: begin
        mul_a = kd_sel;
        mul_b = MB_W'(d_steer);
      end
      MUL_SLOW: begin
        mul_a = cfg.curve_slowdown_gain;
        mul_b = $signed(MB_W'(sq_abs));
      end
      MUL_SP: begin
        mul_a = cfg.speed_prop_gain;
        mul_b = MB_W'(d_spd);
      end
      MUL_SI: begin
        mul_a = cfg.speed_int_gain;
        mul_b = MB_W'(spd_err_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ssp_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign prod_ext = SUM_W'(prod_r);

  // crossing remap
  assign rem_t      = REM_W'($signed(prod_r[CNT_W-1:0])) - REM_W'(REMAP_OFS);
  assign mag_nxt    = rem_t[REM_W-1] ? MAG_W'(-rem_t) : MAG_W'(rem_t);
  assign quo        = prod_r[RECIP_SH+QUO_W-1:RECIP_SH];
  assign quo_s      = $signed({1'b0, quo});
  assign line_remap = neg_r ? -quo_s : quo_s;
  assign e_nxt      = STEER_W'(DSTEER_W'(line_r) - DSTEER_W'(LINE_OFS));

  // speed reference minus negated count
  assign count_big = (wheel_r > CNT_W'(COUNT_LIMIT)) || (wheel_r < -CNT_W'(COUNT_LIMIT));
  assign spd_diff  = count_big ? '0 :
                     $signed({{(DIFF_W-TGT_W){1'b0}}, cfg.target_speed}) + DIFF_W'(wheel_r);

  always_comb begin
    case (ctrl.acc_op)
      ACC_SERVO: acc_nxt = SUM_W'(SERVO_CENTER) <<< Q_BITS;
      ACC_DIFF:  acc_nxt = SUM_W'(spd_diff) <<< Q_BITS;
      ACC_DRIVE: acc_nxt = SUM_W'(drive_r) <<< Q_BITS;
      ACC_ADD:   acc_nxt = acc_r + prod_ext;
      ACC_SLOW:  acc_nxt = (cfg.target_speed != '0) ? acc_r - prod_ext : acc_r;
      default:   acc_nxt = acc_r;
    endcase
  end

  // floor for the servo (clamp hides the difference), truncation otherwise
  assign acc_fl  = $signed(acc_r[SUM_W-1:Q_BITS]);
  assign acc_rnd = acc_r + (acc_r[SUM_W-1] ? SUM_W'(Q_MASK) : SUM_W'(0));
  assign acc_q   = $signed(acc_rnd[SUM_W-1:Q_BITS]);

  // lower limit checked first and wins, also when the limits cross
  always_comb begin
    if ((acc_fl < QSUM_W'(SERVO_MIN)) || (SERVO_MAX < SERVO_MIN)) begin
      servo_nxt = SERVO_W'(SERVO_MIN);
    end else if (acc_fl > QSUM_W'(SERVO_MAX)) begin
      servo_nxt = SERVO_W'(SERVO_MAX);
    end else begin
      servo_nxt = acc_fl[SERVO_W-1:0];
    end
  end

  always_comb begin
    if ((acc_q[QSUM_W-1:SPD_W-1] == '0) || (acc_q[QSUM_W-1:SPD_W-1] == '1)) begin
      spd_err_nxt = acc_q[SPD_W-1:0];
    end else begin
      spd_err_nxt = acc_q[QSUM_W-1] ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
    end
  end

  always_comb begin
    if ((acc_q[QSUM_W-1:DRV_W-1] == '0) || (acc_q[QSUM_W-1:DRV_W-1] == '1)) begin
      drive_nxt = acc_q[DRV_W-1:0];
    end else begin
      drive_nxt = acc_q[QSUM_W-1] ? {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
    end
  end

  assign drv_ext   = (DRV_W+1)'(drive_r);
  assign drv_mag   = drv_ext[DRV_W] ? -drv_ext : drv_ext;
  assign power_nxt = (drv_mag > (DRV_W+1)'(MOTOR_MAX)) ? POWER_W'(MOTOR_MAX)
                                                       : drv_mag[POWER_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      line_r  <= STEER_W'(in_centre_line);
      wheel_r <= in_wheel_count;
    end else if (ctrl.ld_remap) begin
      line_r  <= line_remap;
    end
    if (ctrl.ld_mag) begin
      mag_r <= mag_nxt;
      neg_r <= rem_t[REM_W-1];
    end
    if (ctrl.ld_err) begin
      e_r <= e_nxt;
    end
    if (ctrl.ld_sq) begin
      sq_r <= $signed(prod_r[SQ_W-1:0]);
    end
    acc_r <= acc_nxt;
    if (ctrl.ld_servo) begin
      servo_r <= servo_nxt;
    end
    if (ctrl.ld_serr) begin
      spd_err_r <= spd_err_nxt;
    end
    if (ctrl.ld_out) begin
      servo_out_r <= servo_r;
      power_r     <= power_nxt;
      cw_r        <= drive_r[DRV_W-1] || (drive_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_steer_r <= '0;
      last_speed_r <= '0;
      drive_r      <= '0;
    end else begin
      if (ctrl.ld_servo) begin
        last_steer_r <= e_r;
      end
      if (ctrl.ld_drive) begin
        drive_r      <= drive_nxt;
        last_speed_r <= spd_err_r;
      end
    end
  end

  assign out_servo_angle     = servo_out_r;
  assign out_motor_power     = power_r;
  assign out_motor_clockwise = cw_r;

endmodule
